// File: design/rsrc_pkg.sv
`default_nettype none

package rsrc_pkg;

  localparam int unsigned MaxSegBytes = 1500;
  localparam int unsigned DupSat      = 15;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_TICK = 2'd1,
    OP_ACK  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_START_SEQUENCE = 3'd0,
    REG_TOTAL_BYTES    = 3'd1,
    REG_SEGMENT_BYTES  = 3'd2,
    REG_TIMEOUT_TICKS  = 3'd3,
    REG_DUP_ACK_LIMIT  = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] ack_number;
    logic [31:0] peer_sequence;
  } request_t;

  typedef struct packed {
    logic [31:0] segment_sequence;
    logic [31:0] segment_ack;
    logic [31:0] byte_offset;
    logic [10:0] byte_count;
    logic        is_retransmit;
    logic        all_acked;
  } result_t;

  typedef struct packed {
    logic [31:0] start_sequence;
    logic [31:0] total_bytes;
    logic [10:0] segment_bytes;
    logic [15:0] timeout_ticks;
    logic [3:0]  dup_ack_limit;
  } cfg_t;

  // Held request handed from the input register to the core
  typedef struct packed {
    logic     valid;
    request_t request;
  } stage_t;

endpackage

`default_nettype wire

// File: design/rsrc_cfg_regs.sv
`default_nettype none

module rsrc_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write_enable,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  output rsrc_pkg::cfg_t     cfg
);

  rsrc_pkg::cfg_t cfg_regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.start_sequence <= 32'd0;
      cfg_regs.total_bytes    <= 32'd0;
      cfg_regs.segment_bytes  <= 11'd1400;
      cfg_regs.timeout_ticks  <= 16'd100;
      cfg_regs.dup_ack_limit  <= 4'd3;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        rsrc_pkg::REG_START_SEQUENCE: cfg_regs.start_sequence <= cfg_data;
        rsrc_pkg::REG_TOTAL_BYTES:    cfg_regs.total_bytes    <= cfg_data;
        rsrc_pkg::REG_SEGMENT_BYTES:  cfg_regs.segment_bytes  <= cfg_data[10:0];
        rsrc_pkg::REG_TIMEOUT_TICKS:  cfg_regs.timeout_ticks  <= cfg_data[15:0];
        rsrc_pkg::REG_DUP_ACK_LIMIT:  cfg_regs.dup_ack_limit  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_regs;

endmodule

`default_nettype wire

// File: design/rsrc_in_stage.sv
`default_nettype none

module rsrc_in_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rsrc_pkg::request_t in_request,
  input  wire logic               fire,
  output rsrc_pkg::stage_t        stage
);

  logic               held_valid;
  logic               held_valid_next;
  rsrc_pkg::request_t held_request;
  logic               accept;

  // Hold the request until the core consumes it
  assign in_stall = held_valid & ~fire;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    held_valid_next = held_valid;
    if (accept) begin
      held_valid_next = 1'b1;
    end else if (fire) begin
      held_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_request <= in_request;
    end
  end

  assign stage.valid   = held_valid;
  assign stage.request = held_request;

endmodule

`default_nettype wire

// File: design/rsrc_core.sv
`default_nettype none

module rsrc_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rsrc_pkg::cfg_t   cfg,
  input  wire rsrc_pkg::stage_t stage,
  output logic                  fire,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output rsrc_pkg::result_t     out_result
);

  logic [31:0] next_offset;
  logic [31:0] next_offset_next;
  logic [31:0] base_offset;
  logic [31:0] base_offset_next;
  logic [3:0]  dup_count;
  logic [3:0]  dup_count_next;
  logic [15:0] timer_count;
  logic [15:0] timer_count_next;
  logic [31:0] last_peer_sequence;
  logic [31:0] last_peer_sequence_next;

  logic              result_valid;
  logic              result_valid_next;
  rsrc_pkg::result_t result;
  rsrc_pkg::result_t result_next;

  logic        out_free;
  logic        emit;
  logic        retx;
  logic [10:0] seg_size;
  logic        outstanding;
  logic [31:0] off_sel;
  logic [31:0] left;
  logic [10:0] seg_len;
  logic [15:0] timer_inc;
  logic [15:0] timeout_limit;
  logic [31:0] ack_offset;
  logic [3:0]  dup_inc;
  logic [3:0]  dup_limit;
  logic [31:0] peer_for_ack;

  assign out_free = ~result_valid | ~out_stall;
  assign fire     = stage.valid & out_free;

  always_comb begin
    if (cfg.segment_bytes == 11'd0) begin
      seg_size = 11'd1;
    end else if (cfg.segment_bytes > 11'(rsrc_pkg::MaxSegBytes)) begin
      seg_size = 11'(rsrc_pkg::MaxSegBytes);
    end else begin
      seg_size = cfg.segment_bytes;
    end
  end

  assign outstanding   = (base_offset < next_offset) && (base_offset < cfg.total_bytes);
  assign off_sel       = (stage.request.operation == rsrc_pkg::OP_SEND) ? next_offset
                                                                        : base_offset;
  assign left          = cfg.total_bytes - off_sel;
  assign seg_len       = (left < {21'd0, seg_size}) ? left[10:0] : seg_size;
  assign timer_inc     = timer_count + 16'd1;
  assign timeout_limit = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
  assign ack_offset    = stage.request.ack_number - cfg.start_sequence;
  assign dup_inc       = (dup_count == 4'(rsrc_pkg::DupSat)) ? dup_count : dup_count + 4'd1;
  assign dup_limit     = (cfg.dup_ack_limit == 4'd0) ? 4'd1 : cfg.dup_ack_limit;
  assign peer_for_ack  = (stage.request.operation == rsrc_pkg::OP_ACK)
                       ? stage.request.peer_sequence : last_peer_sequence;

  always_comb begin
    next_offset_next        = next_offset;
    base_offset_next        = base_offset;
    dup_count_next          = dup_count;
    timer_count_next        = timer_count;
    last_peer_sequence_next = last_peer_sequence;
    emit                    = 1'b0;
    retx                    = 1'b0;

    unique case (stage.request.operation)
      rsrc_pkg::OP_SEND: begin
        if (next_offset < cfg.total_bytes) begin
          next_offset_next = next_offset + {21'd0, seg_len};
          timer_count_next = 16'd0;
          emit             = 1'b1;
        end
      end
      rsrc_pkg::OP_TICK: begin
        if (!outstanding) begin
          timer_count_next = 16'd0;
        end else if (timer_inc < timeout_limit) begin
          timer_count_next = timer_inc;
        end else begin
          timer_count_next = 16'd0;
          emit             = 1'b1;
          retx             = 1'b1;
        end
      end
      rsrc_pkg::OP_ACK: begin
        last_peer_sequence_next = stage.request.peer_sequence;
        if (ack_offset > next_offset) begin
          // beyond anything sent: drop
        end else if (ack_offset > base_offset) begin
          base_offset_next = ack_offset;
          dup_count_next   = 4'd0;
          timer_count_next = 16'd0;
        end else if (outstanding) begin
          if (dup_inc < dup_limit) begin
            dup_count_next = dup_inc;
          end else begin
            dup_count_next   = 4'd0;
            timer_count_next = 16'd0;
            emit             = 1'b1;
            retx             = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result_next.segment_sequence = cfg.start_sequence + off_sel;
    result_next.segment_ack      = peer_for_ack + 32'd1;
    result_next.byte_offset      = off_sel;
    result_next.byte_count       = seg_len;
    result_next.is_retransmit    = retx;
    result_next.all_acked        = (base_offset >= cfg.total_bytes);
  end

  always_comb begin
    result_valid_next = result_valid;
    if (fire) begin
      result_valid_next = emit;
    end else if (!out_stall) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_offset        <= 32'd0;
      base_offset        <= 32'd0;
      dup_count          <= 4'd0;
      timer_count        <= 16'd0;
      last_peer_sequence <= 32'd0;
      result_valid       <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
      if (fire) begin
        next_offset        <= next_offset_next;
        base_offset        <= base_offset_next;
        dup_count          <= dup_count_next;
        timer_count        <= timer_count_next;
        last_peer_sequence <= last_peer_sequence_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      result <= result_next;
    end
  end

  assign out_valid  = result_valid;
  assign out_result = result;

  // Acks never move the base past what has been sent
  a_base_le_next: assert property (@(posedge clk) disable iff (rst)
    base_offset <= next_offset)
    else $error("base_offset passed next_offset");

  // A fresh segment ends exactly at the send pointer while it waits
  a_send_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_result.is_retransmit) |->
      (next_offset == out_result.byte_offset + {21'd0, out_result.byte_count}))
    else $error("fresh segment does not end at next_offset");

  // A retransmit always carries the base segment
  a_retx_base: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.is_retransmit) |-> (out_result.byte_offset == base_offset))
    else $error("retransmit not at base_offset");

  // Every emitted segment carries payload
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_result.byte_count != 11'd0))
    else $error("empty segment emitted");

endmodule

`default_nettype wire

// File: design/reliable_sender_retransmit_control_unit.sv
// A request is held in the input register, then its segment is captured in the result register.
// Throughput: one request per cycle unless a waiting segment is stalled; the input register and the
// result register let a new request enter while a finished segment still waits downstream.
// Sends, ticks and acks that produce no segment still take one pass through the core.
// Reset (synchronous, rst high) clears the offsets, counters and valids and loads
// the configuration defaults.
`default_nettype none

module reliable_sender_retransmit_control_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write_enable,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rsrc_pkg::request_t in_request,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rsrc_pkg::result_t       out_result
);

  rsrc_pkg::cfg_t   cfg;
  rsrc_pkg::stage_t stage;
  logic             fire;

  rsrc_cfg_regs u_cfg_regs (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cfg              (cfg)
  );

  rsrc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_request (in_request),
    .fire       (fire),
    .stage      (stage)
  );

  rsrc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .stage      (stage),
    .fire       (fire),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

endmodule

`default_nettype wire

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;
  // PIN_NONE: take the predictor's answer; the others carry a typed-in answer
  typedef enum logic [1:0] {PIN_NONE, PIN_EMPTY, PIN_SEG} pin_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    rsrc_pkg::op_t     op;
    logic [31:0]       arg_a;  // ack_number, or register index
    logic [31:0]       arg_b;  // peer_sequence, or register data
    pin_kind_t         pin;
    rsrc_pkg::result_t want;
  } plan_row_t;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned Phases       = 6;
  localparam int unsigned PhaseItems   = 105;
  localparam logic [2:0]  UnmappedReg  = 3'd7;

  localparam plan_row_t Plan [39] = '{
    // reset defaults: nothing to send
    '{ROW_REQ, rsrc_pkg::OP_SEND, 32'h0, 32'h0, PIN_EMPTY, '0},
    '{ROW_REQ, rsrc_pkg::OP_TICK, 32'h0, 32'h0, PIN_EMPTY, '0},
    '{ROW_REQ, rsrc_pkg::OP_ACK, 32'h0, 32'hFFFF_FFFF, PIN_EMPTY, '0},
    '{ROW_REQ, rsrc_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PIN_EMPTY, '0},
    '{ROW_CFG, rsrc_pkg::OP_NONE, 32'(UnmappedReg), 32'hFFFF_FFFF, PIN_NONE, '0},
    '{ROW_CFG, rsrc_pkg::OP_NONE, 32'(rsrc_pkg::REG_START_SEQUENCE), 32'hFFFF_FFF0,
      PIN_NONE, '0},
    '{ROW_CFG, rsrc_pkg::OP_NONE, 32'(rsrc_pkg::REG_TOTAL_BYTES), 32'd3001, PIN_NONE, '0},
    '{ROW_CFG, rsrc_pkg::OP_NONE, 32'(rsrc_pkg::REG_SEGMENT_BYTES), 32'd1500, PIN_NONE, '0},
    '{ROW_CFG, rsrc_pkg::OP_NONE, 32'(rsrc_pkg::REG_TIMEOUT_TICKS), 32'd2, PIN_NONE, '0},
    '{ROW_CFG, rsrc_pkg::OP_NONE, 32'(rsrc_pkg::REG_DUP_ACK_LIMIT), 32'd2, PIN_NONE, '0},
    // full segments, sequence and ack wrap, short last segment
    '{ROW_REQ, rsrc_pkg::OP_SEND, 32'h0, 32'h0, PIN_SEG,
      '{32'hFFFF_FFF0, 32'h0, 32'h0, 11'd1500, 1'b0, 1'b0}},
    '{ROW_REQ, rsrc_pkg::OP_SEND, 32'h0, 32'h0, PIN_NONE, '0},
    '{ROW_REQ, rsrc_pkg::OP_SEND, 32'h0, 32'h0, PIN_NONE, '0},
    '{ROW_REQ, rsrc_pkg::OP_SEND, 32'h0, 32'h0, PIN_EMPTY, '0},
    '{ROW_REQ, rsrc_pkg::OP_TICK, 32'h0, 32'h0, PIN_EMPTY, '0},
    '{ROW_REQ, rsrc_pkg::OP_TICK, 32'h0, 32'h0, PIN_SEG,
      '{32'hFFFF_FFF0, 32'h0, 32'h0, 11'd1500, 1'b1, 1'b0}},
    '{ROW_REQ, rsrc_pkg::OP_ACK, 32'h0000_05CC, 32'h1234_5678, PIN_EMPTY, '0},
    '{ROW_REQ, rsrc_pkg::OP_ACK, 32'h0000_05CC, 32'h0, PIN_EMPTY, '0},
    '{ROW_REQ, rsrc_pkg::OP_ACK, 32'h0000_05CC, 32'hFFFF_FFFE, PIN_SEG,
      '{32'h0000_05CC, 32'hFFFF_FFFF, 32'd1500, 11'd1500, 1'b1, 1'b0}},
    // ack past next offset, then everything acknowledged
    '{ROW_REQ, rsrc_pkg::OP_ACK, 32'h0000_1378, 32'hA5A5_A5A5, PIN_EMPTY, '0},
    '{ROW_REQ, rsrc_pkg::OP_ACK, 32'h0000_0BA9, 32'h5A5A_5A5A, PIN_EMPTY, '0},
    '{ROW_REQ, rsrc_pkg::OP_TICK, 32'h0, 32'h0, PIN_EMPTY, '0},
    '{ROW_REQ, rsrc_pkg::OP_ACK, 32'h0000_0BA9, 32'h0, PIN_EMPTY, '0},
    // oversize segment, largest timeout and limit, junk in the upper bits
    '{ROW_CFG, rsrc_pkg::OP_NONE, 32'(rsrc_pkg::REG_START_SEQUENCE), 32'h0, PIN_NONE, '0},
    '{ROW_CFG, rsrc_pkg::OP_NONE, 32'(rsrc_pkg::REG_TOTAL_BYTES), 32'hFFFF_FFFF,
      PIN_NONE, '0},
    '{ROW_CFG, rsrc_pkg::OP_NONE, 32'(rsrc_pkg::REG_SEGMENT_BYTES), 32'hFFFF_FFFF,
      PIN_NONE, '0},
    '{ROW_CFG, rsrc_pkg::OP_NONE, 32'(rsrc_pkg::REG_TIMEOUT_TICKS), 32'hFFFF_FFFF,
      PIN_NONE, '0},
    '{ROW_CFG, rsrc_pkg::OP_NONE, 32'(rsrc_pkg::REG_DUP_ACK_LIMIT), 32'hFFFF_FFFF,
      PIN_NONE, '0},
    '{ROW_REQ, rsrc_pkg::OP_SEND, 32'h0, 32'h0, PIN_SEG,
      '{32'd3001, 32'd1, 32'd3001, 11'd1500, 1'b0, 1'b0}},
    '{ROW_REQ, rsrc_pkg::OP_ACK, 32'd3001, 32'd7, PIN_EMPTY, '0},
    '{ROW_REQ, rsrc_pkg::OP_TICK, 32'h0, 32'h0, PIN_EMPTY, '0},
    // zero segment size, timeout and limit act as one
    '{ROW_CFG, rsrc_pkg::OP_NONE, 32'(rsrc_pkg::REG_SEGMENT_BYTES), 32'hFFFF_F800,
      PIN_NONE, '0},
    '{ROW_CFG, rsrc_pkg::OP_NONE, 32'(rsrc_pkg::REG_TIMEOUT_TICKS), 32'hFFFF_0000,
      PIN_NONE, '0},
    '{ROW_CFG, rsrc_pkg::OP_NONE, 32'(rsrc_pkg::REG_DUP_ACK_LIMIT), 32'hFFFF_FFF0,
      PIN_NONE, '0},
    '{ROW_REQ, rsrc_pkg::OP_SEND, 32'h0, 32'h0, PIN_SEG,
      '{32'd4501, 32'd8, 32'd4501, 11'd1, 1'b0, 1'b0}},
    '{ROW_REQ, rsrc_pkg::OP_TICK, 32'h0, 32'h0, PIN_SEG,
      '{32'd3001, 32'd8, 32'd3001, 11'd1, 1'b1, 1'b0}},
    '{ROW_REQ, rsrc_pkg::OP_ACK, 32'd3001, 32'h8000_0000, PIN_SEG,
      '{32'd3001, 32'h8000_0001, 32'd3001, 11'd1, 1'b1, 1'b0}},
    '{ROW_REQ, rsrc_pkg::OP_ACK, 32'd4502, 32'h0, PIN_EMPTY, '0},
    '{ROW_REQ, rsrc_pkg::OP_SEND, 32'h0, 32'h0, PIN_NONE, '0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write_enable = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  rsrc_pkg::request_t in_request = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  rsrc_pkg::result_t  out_result;

  // pinned answer travels with the request so the monitor sees it at acceptance
  pin_kind_t          cur_pin_kind = PIN_NONE;
  rsrc_pkg::result_t  cur_pin_seg = '0;

  // sender's private copy of the block
  rsrc_pkg::cfg_t     model_cfg;
  logic [31:0]        nxt_off, base_off, peer_seq;
  logic [3:0]         dup_cnt;
  logic [15:0]        tmr_cnt;

  rsrc_pkg::result_t  segments_due [$];
  int unsigned        errors = 0;
  int unsigned        cycles = 0;
  int unsigned        burst_left = 0;
  int unsigned        stall_left = 0;
  int unsigned        free_left = 0;

  reliable_sender_retransmit_control_unit u_dut (
    .clk,
    .rst,
    .cfg_write_enable,
    .cfg_index,
    .cfg_data,
    .in_valid,
    .in_stall,
    .in_request,
    .out_valid,
    .out_stall,
    .out_result
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [10:0] seg_size(logic [10:0] raw);
    if (raw == 11'd0) return 11'd1;
    if (raw > 11'(rsrc_pkg::MaxSegBytes)) return 11'(rsrc_pkg::MaxSegBytes);
    return raw;
  endfunction

  function automatic logic [10:0] seg_len_at(logic [31:0] off);
    logic [31:0] left;
    logic [10:0] sz;
    left = model_cfg.total_bytes - off;
    sz = seg_size(model_cfg.segment_bytes);
    return (left < 32'(sz)) ? left[10:0] : sz;
  endfunction

  function automatic rsrc_pkg::result_t make_segment(logic [31:0] off, logic retx);
    rsrc_pkg::result_t s;
    s.segment_sequence = model_cfg.start_sequence + off;
    s.segment_ack      = peer_seq + 32'd1;
    s.byte_offset      = off;
    s.byte_count       = seg_len_at(off);
    s.is_retransmit    = retx;
    s.all_acked        = (base_off >= model_cfg.total_bytes);
    return s;
  endfunction

  function automatic logic predict_segment(input rsrc_pkg::request_t r,
                                           output rsrc_pkg::result_t seg);
    logic [31:0] ack_off;
    logic [15:0] tmo;
    logic [3:0]  dlim;
    logic        busy;
    seg  = '0;
    busy = (base_off < nxt_off) && (base_off < model_cfg.total_bytes);
    tmo  = (model_cfg.timeout_ticks == '0) ? 16'd1 : model_cfg.timeout_ticks;
    dlim = (model_cfg.dup_ack_limit == '0) ? 4'd1 : model_cfg.dup_ack_limit;
    case (r.operation)
      rsrc_pkg::OP_SEND: begin
        if (nxt_off >= model_cfg.total_bytes) return 1'b0;
        seg     = make_segment(nxt_off, 1'b0);
        nxt_off = nxt_off + 32'(seg.byte_count);
        tmr_cnt = '0;
        return 1'b1;
      end
      rsrc_pkg::OP_TICK: begin
        if (!busy) begin
          tmr_cnt = '0;
          return 1'b0;
        end
        tmr_cnt = tmr_cnt + 16'd1;
        if (tmr_cnt < tmo) return 1'b0;
        tmr_cnt = '0;
        seg = make_segment(base_off, 1'b1);
        return 1'b1;
      end
      rsrc_pkg::OP_ACK: begin
        ack_off  = r.ack_number - model_cfg.start_sequence;
        peer_seq = r.peer_sequence;
        if (ack_off > nxt_off) return 1'b0;
        if (ack_off > base_off) begin
          base_off = ack_off;
          dup_cnt  = '0;
          tmr_cnt  = '0;
          return 1'b0;
        end
        if (!busy) return 1'b0;
        if (dup_cnt < 4'(rsrc_pkg::DupSat)) dup_cnt = dup_cnt + 4'd1;
        if (dup_cnt < dlim) return 1'b0;
        dup_cnt = '0;
        tmr_cnt = '0;
        seg = make_segment(base_off, 1'b1);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
    return 1'b0;
  endfunction

  function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // monitor: track config, predict on each accepted request, check each segment
  always @(posedge clk) begin
    rsrc_pkg::result_t want;
    rsrc_pkg::result_t seg;
    logic              hit;
    if (rst) begin
      model_cfg = '{32'h0, 32'h0, 11'd1400, 16'd100, 4'd3};
      nxt_off   = '0;
      base_off  = '0;
      peer_seq  = '0;
      dup_cnt   = '0;
      tmr_cnt   = '0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          rsrc_pkg::REG_START_SEQUENCE: model_cfg.start_sequence = cfg_data;
          rsrc_pkg::REG_TOTAL_BYTES:    model_cfg.total_bytes = cfg_data;
          rsrc_pkg::REG_SEGMENT_BYTES:  model_cfg.segment_bytes = cfg_data[10:0];
          rsrc_pkg::REG_TIMEOUT_TICKS:  model_cfg.timeout_ticks = cfg_data[15:0];
          rsrc_pkg::REG_DUP_ACK_LIMIT:  model_cfg.dup_ack_limit = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_stall === 1'b0) begin
        hit = predict_segment(in_request, want);
        if (cur_pin_kind == PIN_SEG) segments_due.push_back(cur_pin_seg);
        else if (cur_pin_kind == PIN_NONE && hit) segments_due.push_back(want);
      end
      if (out_valid === 1'b1 && !out_stall) begin
        if (segments_due.size() == 0) begin
          $display("%0t: segment %h arrived with none expected", $time, out_result);
          errors++;
        end else begin
          seg = segments_due.pop_front();
          field_check("segment_sequence", seg.segment_sequence,
                      out_result.segment_sequence);
          field_check("segment_ack", seg.segment_ack, out_result.segment_ack);
          field_check("byte_offset", seg.byte_offset, out_result.byte_offset);
          field_check("byte_count", 32'(seg.byte_count), 32'(out_result.byte_count));
          field_check("is_retransmit", 32'(seg.is_retransmit),
                      32'(out_result.is_retransmit));
          field_check("all_acked", 32'(seg.all_acked), 32'(out_result.all_acked));
        end
      end
    end
  end

  // downstream stall: short bursts mostly, now and then long holds or long free runs
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (free_left != 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 2) == 0)
        free_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
                                                : $urandom_range(1, 6);
      else
        stall_left = ($urandom_range(0, 6) == 0) ? $urandom_range(8, 30)
                                                 : $urandom_range(1, 3);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: run timed out", $time);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_request(rsrc_pkg::request_t r, pin_kind_t k, rsrc_pkg::result_t w);
    in_valid     <= 1'b1;
    in_request   <= r;
    cur_pin_kind <= k;
    cur_pin_seg  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // hold off the sender until every segment is out and the pipe has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (segments_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic pace();
    int unsigned r;
    int unsigned g;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 149) == 0) begin
      drain();
    end else begin
      if (burst_left != 0) begin
        burst_left--;
        g = 0;
      end else if (r < 4) begin
        burst_left = $urandom_range(20, 60);
        g = 0;
      end else if (r < 50) begin
        g = 0;
      end else if (r < 85) begin
        g = $urandom_range(1, 3);
      end else if (r < 97) begin
        g = $urandom_range(4, 10);
      end else begin
        g = $urandom_range(20, 40);
      end
      if (g != 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= d;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    rsrc_pkg::request_t req;
    int unsigned        fed;
    int unsigned        sel;
    int unsigned        sz;
    logic [32:0]        wide;
    logic [32:0]        span_end;
    logic [31:0]        ack_off;
    logic [31:0]        start_raw;
    logic [31:0]        total_raw;
    logic [31:0]        word;
    logic [10:0]        seg_raw;
    logic [15:0]        tmo_raw;
    logic [3:0]         dlim_raw;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (Plan[i]) begin
      if (Plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(Plan[i].arg_a[2:0], Plan[i].arg_b);
      end else begin
        req.operation     = Plan[i].op;
        req.ack_number    = Plan[i].arg_a;
        req.peer_sequence = Plan[i].arg_b;
        send_request(req, Plan[i].pin, Plan[i].want);
        pace();
      end
    end

    for (int p = 0; p < Phases; p++) begin
      drain();
      start_raw = $urandom;
      seg_raw   = 11'($urandom_range(1, 300));
      tmo_raw   = 16'($urandom_range(1, 10));
      dlim_raw  = 4'($urandom_range(1, 6));
      case (p)
        0: begin
          seg_raw  = 11'($urandom_range(1, 8));
          tmo_raw  = 16'($urandom_range(1, 4));
          dlim_raw = 4'($urandom_range(1, 4));
        end
        1: begin
          start_raw = 32'hFFFF_FFFF;
          seg_raw   = 11'(rsrc_pkg::MaxSegBytes);
          tmo_raw   = '0;
          dlim_raw  = 4'(rsrc_pkg::DupSat);
        end
        2: begin
          start_raw = '0;
          seg_raw   = 11'h7FF;
          tmo_raw   = 16'hFFFF;
          dlim_raw  = '0;
        end
        default: ;
      endcase
      // size the transfer so that it runs out partway through the phase
      sz = 32'(seg_size(seg_raw));
      span_end = {1'b0, nxt_off} + 33'(sz * $urandom_range(10, 40))
                 - 33'($urandom_range(0, sz - 1));
      total_raw = (span_end[32] || p == 2) ? 32'hFFFF_FFFF : span_end[31:0];
      write_reg(rsrc_pkg::REG_START_SEQUENCE, start_raw);
      write_reg(rsrc_pkg::REG_TOTAL_BYTES, total_raw);
      word = $urandom;
      word[10:0] = seg_raw;
      write_reg(rsrc_pkg::REG_SEGMENT_BYTES, word);
      word = $urandom;
      word[15:0] = tmo_raw;
      write_reg(rsrc_pkg::REG_TIMEOUT_TICKS, word);
      word = $urandom;
      word[3:0] = dlim_raw;
      write_reg(rsrc_pkg::REG_DUP_ACK_LIMIT, word);

      fed = 0;
      while (fed < PhaseItems) begin
        sel = $urandom_range(0, 99);
        req.ack_number    = $urandom;
        req.peer_sequence = $urandom;
        if (sel < 38) req.operation = rsrc_pkg::OP_SEND;
        else if (sel < 62) req.operation = rsrc_pkg::OP_TICK;
        else if (sel < 96) req.operation = rsrc_pkg::OP_ACK;
        else req.operation = rsrc_pkg::OP_NONE;
        // aim most acks at the base, at segment edges, or just past the end
        if (req.operation == rsrc_pkg::OP_ACK) begin
          sel = $urandom_range(0, 99);
          sz  = 32'(seg_size(model_cfg.segment_bytes));
          if (sel < 40) begin
            ack_off = base_off;
          end else if (sel < 75) begin
            wide = {1'b0, base_off} + 33'(sz * $urandom_range(1, 4));
            ack_off = (wide > {1'b0, nxt_off}) ? nxt_off : wide[31:0];
          end else if (sel < 85) begin
            ack_off = nxt_off + 32'($urandom_range(1, 3000));
          end else begin
            ack_off = req.ack_number - model_cfg.start_sequence;
          end
          req.ack_number = model_cfg.start_sequence + ack_off;
        end
        send_request(req, PIN_NONE, '0);
        if (req.operation != rsrc_pkg::OP_NONE) fed++;
        pace();
      end
    end

    drain();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// File: files.f
design/rsrc_pkg.sv
design/rsrc_cfg_regs.sv
design/rsrc_in_stage.sv
design/rsrc_core.sv
design/reliable_sender_retransmit_control_unit.sv
bench/tb_top.sv
